// ----- hdl/ps2ma_pkg.sv -----
package ps2ma_pkg;

	localparam int ACCUM_WIDTH = 16;
	localparam int COUNT_WIDTH = 32;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_POLL = 1'b1;

	localparam int HDR_ALIGN_BIT = 3;
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;
	localparam int HDR_XOVF_BIT  = 6;
	localparam int HDR_YOVF_BIT  = 7;

	typedef logic signed [ACCUM_WIDTH-1:0] acc_t;
	typedef logic [COUNT_WIDTH-1:0]        count_t;
	typedef logic signed [8:0]             delta_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       from_aux;
	} cmd_t;

	typedef struct packed {
		acc_t       delta_x;
		acc_t       delta_y;
		logic [2:0] button_bits;
		logic       packet_done;
		logic       byte_dropped;
		count_t     resync_total;
		count_t     foreign_total;
	} report_t;

	function automatic delta_t axis_delta(logic [7:0] mag, logic neg, logic ovf);
		delta_t d;
		d = ovf ? 9'sd0 : $signed({neg, mag});
		return d;
	endfunction

	function automatic acc_t sat_add(acc_t a, delta_t d);
		logic signed [ACCUM_WIDTH:0] s;
		acc_t                        r;
		s = $signed({a[ACCUM_WIDTH-1], a}) + $signed({{(ACCUM_WIDTH-8){d[8]}}, d});
		if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
			r = s[ACCUM_WIDTH] ? $signed({1'b1, {(ACCUM_WIDTH-1){1'b0}}})
			                   : $signed({1'b0, {(ACCUM_WIDTH-1){1'b1}}});
		end else begin
			r = s[ACCUM_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/ps2ma_cmd_if.sv -----
interface ps2ma_cmd_if;
	logic              valid;
	logic              ready;
	ps2ma_pkg::cmd_t   item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// ----- hdl/ps2ma_report_if.sv -----
interface ps2ma_report_if;
	logic               valid;
	logic               ready;
	ps2ma_pkg::report_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

// ----- hdl/ps2_mouse_packet_accumulator.sv -----
// PS/2 mouse packet accumulator.
// cmd carries one item per controller byte (action 0, with the aux-port tag)
// or a poll request (action 1). report carries exactly one item per cmd item:
// accumulated X/Y motion, button levels, packet/drop flags and the resync and
// foreign-byte counters after that item.
// Aux bytes build three-byte packets; a header without bit 3 set is dropped
// and counted as a resync. A finished packet adds its deltas into saturating
// signed accumulators and overwrites the buttons. A poll reports the motion
// and then clears it.
// The report item is registered: it is valid in the cycle after its cmd item is accepted.
// Throughput: one item per cycle while report is not stalled, set by the single result register.
// While report is stalled the result register holds; cmd stays ready only if
// report is taken in the same cycle, so no item is lost or repeated.
// Reset clears the packet position, accumulators, buttons, counters and the
// result register's valid; report shows nothing until the first cmd item.
module ps2_mouse_packet_accumulator (
	input  logic                  clk,
	input  logic                  arst_n,
	ps2ma_cmd_if.sink             cmd,
	ps2ma_report_if.source        report
);

	localparam logic [1:0] POS_HEAD = 2'd0;
	localparam logic [1:0] POS_X    = 2'd1;
	localparam logic [1:0] POS_Y    = 2'd2;

	logic [1:0]          pos_q, pos_d;
	logic [7:0]          header_q;
	logic [7:0]          xmag_q;
	ps2ma_pkg::acc_t     acc_x_q, acc_x_d;
	ps2ma_pkg::acc_t     acc_y_q, acc_y_d;
	logic [2:0]          buttons_q, buttons_d;
	ps2ma_pkg::count_t   resync_q, resync_d;
	ps2ma_pkg::count_t   foreign_q, foreign_d;
	logic                header_we, xmag_we;
	logic                accept;
	logic                out_valid_q;
	ps2ma_pkg::report_t  result_d, result_q;

	assign cmd.ready    = !out_valid_q || report.ready;
	assign accept       = cmd.valid && cmd.ready;
	assign report.valid = out_valid_q;
	assign report.item  = result_q;

	always_comb begin
		pos_d     = pos_q;
		acc_x_d   = acc_x_q;
		acc_y_d   = acc_y_q;
		buttons_d = buttons_q;
		resync_d  = resync_q;
		foreign_d = foreign_q;
		header_we = 1'b0;
		xmag_we   = 1'b0;
		result_d  = '0;
		if (cmd.item.action == ps2ma_pkg::ACT_POLL) begin
			acc_x_d = '0;
			acc_y_d = '0;
			result_d.delta_x = acc_x_q;
			result_d.delta_y = acc_y_q;
		end else begin
			if (!cmd.item.from_aux) begin
				foreign_d = foreign_q + ps2ma_pkg::count_t'(1);
				result_d.byte_dropped = 1'b1;
			end else begin
				unique case (pos_q)
					POS_X: begin
						xmag_we = 1'b1;
						pos_d   = POS_Y;
					end
					POS_Y: begin
						acc_x_d = ps2ma_pkg::sat_add(acc_x_q, ps2ma_pkg::axis_delta(xmag_q,
							header_q[ps2ma_pkg::HDR_XSIGN_BIT],
							header_q[ps2ma_pkg::HDR_XOVF_BIT]));
						acc_y_d = ps2ma_pkg::sat_add(acc_y_q, ps2ma_pkg::axis_delta(
							cmd.item.data_byte,
							header_q[ps2ma_pkg::HDR_YSIGN_BIT],
							header_q[ps2ma_pkg::HDR_YOVF_BIT]));
						buttons_d = header_q[2:0];
						pos_d     = POS_HEAD;
						result_d.packet_done = 1'b1;
					end
					default: begin
						if (!cmd.item.data_byte[ps2ma_pkg::HDR_ALIGN_BIT]) begin
							resync_d = resync_q + ps2ma_pkg::count_t'(1);
							pos_d    = POS_HEAD;
							result_d.byte_dropped = 1'b1;
						end else begin
							header_we = 1'b1;
							pos_d     = POS_X;
						end
					end
				endcase
			end
			result_d.delta_x = acc_x_d;
			result_d.delta_y = acc_y_d;
		end
		result_d.button_bits   = buttons_d;
		result_d.resync_total  = resync_d;
		result_d.foreign_total = foreign_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_HEAD;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			buttons_q   <= '0;
			resync_q    <= '0;
			foreign_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q     <= pos_d;
				acc_x_q   <= acc_x_d;
				acc_y_q   <= acc_y_d;
				buttons_q <= buttons_d;
				resync_q  <= resync_d;
				foreign_q <= foreign_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && header_we) begin
			header_q <= cmd.item.data_byte;
		end
		if (accept && xmag_we) begin
			xmag_q <= cmd.item.data_byte;
		end
		if (accept) begin
			result_q <= result_d;
		end
	end

	a_pos_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("packet position reached an unused code");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.packet_done && result_q.byte_dropped))
		else $error("report flags both packet done and byte dropped");

	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.item.action == ps2ma_pkg::ACT_POLL
		|=> acc_x_q == '0 && acc_y_q == '0 && !result_q.packet_done
			&& !result_q.byte_dropped)
		else $error("poll did not clear motion or raised a flag");

	a_foreign_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.item.action == ps2ma_pkg::ACT_BYTE && !cmd.item.from_aux
		|=> foreign_q == $past(foreign_q) + ps2ma_pkg::count_t'(1) && pos_q == $past(pos_q))
		else $error("foreign byte not counted or disturbed packet position");

	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result_d.packet_done |-> pos_q == POS_Y)
		else $error("packet completed outside the third byte");

endmodule

// ----- test/tb_ps2_mouse_packet_accumulator.sv -----
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_accumulator;

	localparam int         CLK_PERIOD  = 20;
	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [7:0] ALIGN_MASK  = 8'h01 << ps2ma_pkg::HDR_ALIGN_BIT;

	logic clk = 1'b0;
	logic arst_n;

	ps2ma_cmd_if    cmd_ch();
	ps2ma_report_if report_ch();

	ps2_mouse_packet_accumulator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.report (report_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	ps2ma_pkg::cmd_t    pending_cmds[$];
	ps2ma_pkg::report_t expected_reports[$];
	int      queued_count   = 0;
	int      accepted_count = 0;
	int      received_count = 0;
	int      error_count    = 0;
	int      cycle_count    = 0;

	logic [1:0]        mouse_pos   = '0;
	logic [7:0]        mouse_hdr   = '0;
	logic [7:0]        mouse_xmag  = '0;
	ps2ma_pkg::acc_t   motion_x    = '0;
	ps2ma_pkg::acc_t   motion_y    = '0;
	logic [2:0]        button_lvl  = '0;
	ps2ma_pkg::count_t resyncs     = '0;
	ps2ma_pkg::count_t foreigns    = '0;

	function automatic longint axis_motion(logic [7:0] mag, logic neg, logic ovf);
		if (ovf)
			return 0;
		return neg ? longint'(mag) - 256 : longint'(mag);
	endfunction

	function automatic ps2ma_pkg::acc_t clamp_add(ps2ma_pkg::acc_t acc, longint step);
		longint lim;
		longint sum;
		lim = longint'(1) <<< (ps2ma_pkg::ACCUM_WIDTH - 1);
		sum = longint'(acc) + step;
		if (sum > lim - 1)
			sum = lim - 1;
		if (sum < -lim)
			sum = -lim;
		return sum[ps2ma_pkg::ACCUM_WIDTH-1:0];
	endfunction

	function automatic ps2ma_pkg::report_t advance_mouse(ps2ma_pkg::cmd_t c);
		ps2ma_pkg::report_t r;
		r = '0;
		if (c.action == ps2ma_pkg::ACT_POLL) begin
			r.delta_x = motion_x;
			r.delta_y = motion_y;
			motion_x  = '0;
			motion_y  = '0;
		end else begin
			if (!c.from_aux) begin
				foreigns++;
				r.byte_dropped = 1'b1;
			end else if (mouse_pos == 2'd1) begin
				mouse_xmag = c.data_byte;
				mouse_pos  = 2'd2;
			end else if (mouse_pos == 2'd2) begin
				motion_x = clamp_add(motion_x, axis_motion(mouse_xmag,
					mouse_hdr[ps2ma_pkg::HDR_XSIGN_BIT], mouse_hdr[ps2ma_pkg::HDR_XOVF_BIT]));
				motion_y = clamp_add(motion_y, axis_motion(c.data_byte,
					mouse_hdr[ps2ma_pkg::HDR_YSIGN_BIT], mouse_hdr[ps2ma_pkg::HDR_YOVF_BIT]));
				button_lvl    = mouse_hdr[2:0];
				mouse_pos     = 2'd0;
				r.packet_done = 1'b1;
			end else if (!c.data_byte[ps2ma_pkg::HDR_ALIGN_BIT]) begin
				mouse_pos = 2'd0;
				resyncs++;
				r.byte_dropped = 1'b1;
			end else begin
				mouse_hdr = c.data_byte;
				mouse_pos = 2'd1;
			end
			r.delta_x = motion_x;
			r.delta_y = motion_y;
		end
		r.button_bits   = button_lvl;
		r.resync_total  = resyncs;
		r.foreign_total = foreigns;
		return r;
	endfunction

	function automatic int draw_gap(int n, int period);
		return ((n / period) % 3 == 0) ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic void compare_field(string field, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_report(ps2ma_pkg::report_t got);
		ps2ma_pkg::report_t want;
		if (expected_reports.size() == 0) begin
			$error("report item with no expectation pending");
			error_count++;
			return;
		end
		want = expected_reports.pop_front();
		compare_field("delta_x", want.delta_x, got.delta_x);
		compare_field("delta_y", want.delta_y, got.delta_y);
		compare_field("button_bits", want.button_bits, got.button_bits);
		compare_field("packet_done", want.packet_done, got.packet_done);
		compare_field("byte_dropped", want.byte_dropped, got.byte_dropped);
		compare_field("resync_total", want.resync_total, got.resync_total);
		compare_field("foreign_total", want.foreign_total, got.foreign_total);
	endfunction

	logic cmd_busy;
	int   cmd_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_busy = 1'b0;
			cmd_gap  = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_reports.push_back(advance_mouse(cmd_ch.item));
				accepted_count++;
				cmd_busy = 1'b0;
				cmd_gap  = draw_gap(accepted_count, 40);
			end
			if (!cmd_busy) begin
				if (cmd_gap > 0)
					cmd_gap--;
				else if (pending_cmds.size() > 0) begin
					cmd_ch.item <= pending_cmds.pop_front();
					cmd_busy = 1'b1;
				end
			end
			cmd_ch.valid <= cmd_busy;
		end
	end

	int report_stall;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_ch.ready <= 1'b0;
			report_stall = 0;
		end else begin
			if (report_ch.valid && report_ch.ready) begin
				check_report(report_ch.item);
				received_count++;
				report_stall = draw_gap(received_count, 55);
			end
			if (report_stall > 0) begin
				report_stall--;
				report_ch.ready <= 1'b0;
			end else begin
				report_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** ps2_mouse_packet_accumulator: FAILED **");
			$finish;
		end
	end

	task automatic queue_cmd(logic act, logic [7:0] data, logic aux);
		ps2ma_pkg::cmd_t c;
		c.action    = act;
		c.data_byte = data;
		c.from_aux  = aux;
		pending_cmds.push_back(c);
		queued_count++;
	endtask

	task automatic queue_packet_byte(logic [7:0] data);
		if ($urandom_range(0, 9) == 0)
			queue_cmd(ps2ma_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, data, 1'b1);
	endtask

	function automatic logic [7:0] steer_mag(logic neg);
		return neg ? 8'($urandom_range(0, 31)) : 8'($urandom_range(224, 255));
	endfunction

	task automatic queue_random_segment(int n_items, int drift);
		int         start;
		int         pick;
		logic [7:0] hdr;
		start = queued_count;
		if (drift != 0)
			queue_cmd(ps2ma_pkg::ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom));
		while (queued_count - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < ((drift != 0) ? 3 : 8))
				queue_cmd(ps2ma_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), 1'b1);
			else if (pick < ((drift != 0) ? 6 : 14))
				queue_cmd(ps2ma_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
			else if (drift == 0 && pick < 22)
				queue_cmd(ps2ma_pkg::ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom));
			else begin
				hdr = 8'($urandom_range(0, 255)) | ALIGN_MASK;
				if (drift != 0) begin
					hdr[ps2ma_pkg::HDR_XSIGN_BIT] = (drift < 0);
					hdr[ps2ma_pkg::HDR_YSIGN_BIT] = (drift > 0);
					hdr[ps2ma_pkg::HDR_XOVF_BIT]  = ($urandom_range(0, 15) == 0);
					hdr[ps2ma_pkg::HDR_YOVF_BIT]  = ($urandom_range(0, 15) == 0);
				end
				queue_packet_byte(hdr);
				queue_packet_byte((drift != 0) ? steer_mag(hdr[ps2ma_pkg::HDR_XSIGN_BIT])
				                               : 8'($urandom_range(0, 255)));
				queue_packet_byte((drift != 0) ? steer_mag(hdr[ps2ma_pkg::HDR_YSIGN_BIT])
				                               : 8'($urandom_range(0, 255)));
			end
		end
		if (drift != 0)
			queue_cmd(ps2ma_pkg::ACT_POLL, 8'($urandom_range(0, 255)), 1'($urandom));
	endtask

	task automatic wait_idle();
		while (accepted_count != queued_count || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.item     = '0;
		report_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		queue_cmd(ps2ma_pkg::ACT_POLL, 8'h00, 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'hFF, 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h00, 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h00, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'hF7, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h0F, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'hFF, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h00, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h38, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h00, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h01, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'hFD, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h7F, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h80, 1'b1);
		// foreign bytes inside a packet keep the position
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h0A, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h55, 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h10, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'hAA, 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h20, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_POLL, 8'hFF, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_POLL, 8'h00, 1'b0);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h4B, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'h80, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_BYTE, 8'hFF, 1'b1);
		queue_cmd(ps2ma_pkg::ACT_POLL, 8'h00, 1'b0);
		wait_idle();

		queue_random_segment(300, 0);
		wait_idle();
		queue_random_segment(550, 1);
		wait_idle();
		queue_random_segment(550, -1);
		wait_idle();
		queue_random_segment(300, 0);
		wait_idle();
		repeat (4) @(posedge clk);

		if (error_count == 0)
			$display("** ps2_mouse_packet_accumulator: PASSED **");
		else
			$display("** ps2_mouse_packet_accumulator: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/ps2ma_pkg.sv
hdl/ps2ma_cmd_if.sv
hdl/ps2ma_report_if.sv
hdl/ps2_mouse_packet_accumulator.sv
test/tb_ps2_mouse_packet_accumulator.sv
